>>> rtl/fgn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgn_pkg
// Shared types, widths and constant tables of the fractal gradient noise block.
// ----------------------------------------------------------------------------
package fgn_pkg;

    localparam int PERM_SIZE_DEF   = 256;
    localparam int MAX_OCTAVES_DEF = 8;

    localparam int COORD_W   = 16;
    localparam int FREQ_W    = 24;
    localparam int PROD_W    = COORD_W + FREQ_W;
    localparam int SHIFT_W   = PROD_W + 16;
    localparam int INT_LSB   = 24;
    localparam int FRAC_W    = 16;
    localparam int PERM_W    = 8;
    localparam int PERS_W    = 16;
    localparam int OCT_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int AMP_W     = 17;
    localparam int GC_W      = 18;
    localparam int DOT_W     = 20;
    localparam int BL_W      = 22;
    localparam int CURVE_W   = 17;
    localparam int WT_W      = 17;
    localparam int COS_FR_W  = 12;
    localparam int COS_PR_W  = 25;
    localparam int ACC_W     = 28;
    localparam int OUT_W     = 24;

    localparam int FRONT_STAGES = 3;
    localparam int CELL_STAGES  = 10;

    localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(65536);
    localparam logic signed [GC_W-1:0] GRAD_ONE  = GC_W'(65536);
    localparam logic signed [GC_W-1:0] GRAD_DIAG = GC_W'(46341);

    localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(1048575);
    localparam logic signed [ACC_W-1:0] ACC_LO = -ACC_W'(1048576);
    localparam logic signed [OUT_W-1:0] OUT_MAX = OUT_W'(8388607);
    localparam logic signed [OUT_W-1:0] OUT_MIN = OUT_W'(8388608);

    // Weight (1 - cos(pi*c)) / 2 sampled at sixteenths, Q1.16.
    localparam logic [WT_W-1:0] COS_WEIGHT [17] = '{
        17'd0,     17'd630,   17'd2494,  17'd5522,  17'd9598,  17'd14563,
        17'd20228, 17'd26375, 17'd32768, 17'd39161, 17'd45308, 17'd50973,
        17'd55938, 17'd60014, 17'd63042, 17'd64906, 17'd65536
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OCTAVES = 2'd0,
        REG_PERSIST = 2'd1,
        REG_INTERP  = 2'd2,
        REG_FREQ    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [OCT_W-1:0]  octave_count;
        logic [PERS_W-1:0] persistence;
        logic              interp_mode;
        logic [FREQ_W-1:0] base_frequency;
    } cfg_t;

    // One beat travelling down the octave chain.
    typedef struct packed {
        logic                    valid;
        logic                    eval;
        logic [PERM_W-1:0]       widx;
        logic [PERM_W-1:0]       wval;
        logic [PROD_W-1:0]       px;
        logic [PROD_W-1:0]       py;
        logic [AMP_W-1:0]        amp;
        logic signed [ACC_W-1:0] acc;
    } beat_t;

    function automatic logic signed [GC_W-1:0] grad_x(input logic [2:0] g);
        logic signed [GC_W-1:0] v;
        unique case (g)
            3'd0: v = GRAD_ONE;
            3'd1: v = GRAD_DIAG;
            3'd2: v = '0;
            3'd3: v = -GRAD_DIAG;
            3'd4: v = -GRAD_ONE;
            3'd5: v = -GRAD_DIAG;
            3'd6: v = '0;
            3'd7: v = GRAD_DIAG;
        endcase
        return v;
    endfunction

    function automatic logic signed [GC_W-1:0] grad_y(input logic [2:0] g);
        logic signed [GC_W-1:0] v;
        unique case (g)
            3'd0: v = '0;
            3'd1: v = GRAD_DIAG;
            3'd2: v = GRAD_ONE;
            3'd3: v = GRAD_DIAG;
            3'd4: v = '0;
            3'd5: v = -GRAD_DIAG;
            3'd6: v = -GRAD_ONE;
            3'd7: v = -GRAD_DIAG;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/fgn_perm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgn_perm_ram
// Permutation table copy: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module fgn_perm_ram #(
    parameter int DEPTH = fgn_pkg::PERM_SIZE_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [fgn_pkg::PERM_W-1:0] wdata,
    input  logic [AW-1:0]             raddr_a,
    input  logic [AW-1:0]             raddr_b,
    output logic [fgn_pkg::PERM_W-1:0] rdata_a,
    output logic [fgn_pkg::PERM_W-1:0] rdata_b
);

    logic [fgn_pkg::PERM_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> rtl/fgn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgn_front
// Scales the coordinate by the base frequency and reduces the integer cell
// modulo the table size, one byte of the cell per stage.
// ----------------------------------------------------------------------------
module fgn_front #(
    parameter int PERM_SIZE = fgn_pkg::PERM_SIZE_DEF,
    localparam int PIDX_W = $clog2(PERM_SIZE)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic                        op,
    input  logic [fgn_pkg::COORD_W-1:0] coord_x,
    input  logic [fgn_pkg::COORD_W-1:0] coord_y,
    input  logic [fgn_pkg::PERM_W-1:0]  perm_index,
    input  logic [fgn_pkg::PERM_W-1:0]  perm_value,
    input  logic [fgn_pkg::FREQ_W-1:0]  base_frequency,
    output fgn_pkg::beat_t              beat_out,
    output logic [PIDX_W-1:0]           res_x,
    output logic [PIDX_W-1:0]           res_y
);

    // Shifts eight more bits into a residue, reducing after each bit.
    function automatic logic [PIDX_W-1:0] fold8(input logic [PIDX_W-1:0] r_in,
                                                input logic [7:0] bits);
        logic [PIDX_W:0]   t;
        logic [PIDX_W-1:0] r;
        r = r_in;
        for (int i = 7; i >= 0; i--)
        begin
            t = {r, bits[i]};
            if (t >= (PIDX_W+1)'(PERM_SIZE))
            begin
                t = t - (PIDX_W+1)'(PERM_SIZE);
            end
            r = t[PIDX_W-1:0];
        end
        return r;
    endfunction

    fgn_pkg::beat_t b1_reg, b1_next, b2_reg;
    logic [PIDX_W-1:0] rx2_reg, ry2_reg, rx3_reg, ry3_reg;
    fgn_pkg::beat_t b3_reg;

    always_comb
    begin
        b1_next       = '0;
        b1_next.valid = accept;
        b1_next.eval  = op;
        b1_next.widx  = perm_index;
        b1_next.wval  = perm_value;
        b1_next.px    = coord_x * base_frequency;
        b1_next.py    = coord_y * base_frequency;
        b1_next.amp   = fgn_pkg::AMP_ONE;
        b1_next.acc   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_reg <= '0;
            b2_reg <= '0;
            b3_reg <= '0;
        end
        else
        begin
            b1_reg <= b1_next;
            b2_reg <= b1_reg;
            b3_reg <= b2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rx2_reg <= fold8('0, b1_reg.px[39:32]);
        ry2_reg <= fold8('0, b1_reg.py[39:32]);
        rx3_reg <= fold8(rx2_reg, b2_reg.px[31:24]);
        ry3_reg <= fold8(ry2_reg, b2_reg.py[31:24]);
    end

    assign beat_out = b3_reg;
    assign res_x    = rx3_reg;
    assign res_y    = ry3_reg;

endmodule

>>> rtl/fgn_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgn_cell
// One octave: hashes the four corners through its own table copies, takes
// the gradient dot products, blends them and adds the weighted result.
// ----------------------------------------------------------------------------
module fgn_cell #(
    parameter int PERM_SIZE = fgn_pkg::PERM_SIZE_DEF,
    parameter int OCTAVE    = 0,
    localparam int PIDX_W   = $clog2(PERM_SIZE)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fgn_pkg::cfg_t     cfg,
    input  fgn_pkg::beat_t    beat_in,
    input  logic [PIDX_W-1:0] res_x_in,
    input  logic [PIDX_W-1:0] res_y_in,
    output fgn_pkg::beat_t    beat_out,
    output logic [PIDX_W-1:0] res_x_out,
    output logic [PIDX_W-1:0] res_y_out
);

    localparam int GC_W  = fgn_pkg::GC_W;
    localparam int DOT_W = fgn_pkg::DOT_W;
    localparam int BL_W  = fgn_pkg::BL_W;
    localparam int FW    = fgn_pkg::FRAC_W;
    localparam int PW    = fgn_pkg::PERM_W;

    function automatic logic [PIDX_W-1:0] fold1(input logic [PIDX_W-1:0] r,
                                                input logic b);
        logic [PIDX_W:0] t;
        t = {r, b};
        if (t >= (PIDX_W+1)'(PERM_SIZE))
        begin
            t = t - (PIDX_W+1)'(PERM_SIZE);
        end
        return t[PIDX_W-1:0];
    endfunction

    function automatic logic [PIDX_W-1:0] add_mod(input logic [PIDX_W-1:0] a,
                                                  input logic [PIDX_W-1:0] b);
        logic [PIDX_W:0] t;
        t = (PIDX_W+1)'(a) + (PIDX_W+1)'(b);
        if (t >= (PIDX_W+1)'(PERM_SIZE))
        begin
            t = t - (PIDX_W+1)'(PERM_SIZE);
        end
        return t[PIDX_W-1:0];
    endfunction

    function automatic logic [PIDX_W-1:0] inc_mod(input logic [PIDX_W-1:0] a);
        logic [PIDX_W-1:0] r;
        if (a == PIDX_W'(PERM_SIZE - 1))
        begin
            r = '0;
        end
        else
        begin
            r = a + 1'b1;
        end
        return r;
    endfunction

    function automatic logic signed [DOT_W-1:0] corner_dot(
        input logic [2:0]             g,
        input logic signed [GC_W-1:0] dx,
        input logic signed [GC_W-1:0] dy
    );
        logic signed [2*GC_W-1:0] px, py;
        logic signed [2*GC_W:0]   sum;
        px  = (2*GC_W)'(fgn_pkg::grad_x(g));
        py  = (2*GC_W)'(fgn_pkg::grad_y(g));
        px  = px * (2*GC_W)'(dx);
        py  = py * (2*GC_W)'(dy);
        sum = (2*GC_W+1)'(px) + (2*GC_W+1)'(py);
        return DOT_W'(sum >>> FW);
    endfunction

    // Table values reduced modulo the table size.
    logic [PIDX_W-1:0] row_mod [256];
    for (genvar gi = 0; gi < 256; gi++)
    begin : g_row_mod
        assign row_mod[gi] = PIDX_W'(gi % PERM_SIZE);
    end

    // ---------------- stage 0: split the scaled coordinate, read rows
    logic [fgn_pkg::SHIFT_W-1:0] sx0, sy0;
    logic [FW-1:0]     fx0, fy0;
    logic [2*FW-1:0]   sqx0, sqy0;
    logic [PIDX_W-1:0] ry1_0;
    logic              wr0;

    assign sx0   = fgn_pkg::SHIFT_W'(beat_in.px) << OCTAVE;
    assign sy0   = fgn_pkg::SHIFT_W'(beat_in.py) << OCTAVE;
    assign fx0   = sx0[fgn_pkg::INT_LSB-1 -: FW];
    assign fy0   = sy0[fgn_pkg::INT_LSB-1 -: FW];
    assign sqx0  = fx0 * fx0;
    assign sqy0  = fy0 * fy0;
    assign ry1_0 = inc_mod(res_y_in);
    assign wr0   = beat_in.valid && !beat_in.eval &&
                   (32'(beat_in.widx) < 32'(PERM_SIZE));

    logic [PW-1:0] row0_1, row1_1;

    fgn_perm_ram #(.DEPTH(PERM_SIZE)) u_row_ram (
        .clk     (clk),
        .we      (wr0),
        .waddr   (PIDX_W'(beat_in.widx)),
        .wdata   (beat_in.wval),
        .raddr_a (res_y_in),
        .raddr_b (ry1_0),
        .rdata_a (row0_1),
        .rdata_b (row1_1)
    );

    fgn_pkg::beat_t b1_reg, b2_reg, b3_reg, b4_reg, b5_reg;
    fgn_pkg::beat_t b6_reg, b7_reg, b8_reg, b9_reg, b10_reg;
    fgn_pkg::beat_t b9_next, b10_next;

    logic [PIDX_W-1:0] nrx_reg [10];
    logic [PIDX_W-1:0] nry_reg [10];

    logic [PIDX_W-1:0] rx_1_reg, rx1_1_reg;
    logic [FW-1:0]     fx_1_reg, fy_1_reg, t2x_1_reg, t2y_1_reg;

    always_ff @(posedge clk)
    begin
        rx_1_reg   <= res_x_in;
        rx1_1_reg  <= inc_mod(res_x_in);
        fx_1_reg   <= fx0;
        fy_1_reg   <= fy0;
        t2x_1_reg  <= sqx0[2*FW-1:FW];
        t2y_1_reg  <= sqy0[2*FW-1:FW];
        nrx_reg[0] <= fold1(res_x_in, sx0[fgn_pkg::INT_LSB-1]);
        nry_reg[0] <= fold1(res_y_in, sy0[fgn_pkg::INT_LSB-1]);
        for (int i = 1; i < 10; i++)
        begin
            nrx_reg[i] <= nrx_reg[i-1];
            nry_reg[i] <= nry_reg[i-1];
        end
    end

    // ---------------- stage 1: corner addresses, read gradients
    logic [PIDX_W-1:0] rm0_1, rm1_1, a_s1, a_t1, a_u1, a_v1;
    logic [2*FW-1:0]   cbx1, cby1;
    logic              wr1;
    logic [PW-1:0]     g_s2, g_t2, g_u2, g_v2;

    assign rm0_1 = row_mod[row0_1];
    assign rm1_1 = row_mod[row1_1];
    assign a_s1  = add_mod(rx_1_reg, rm0_1);
    assign a_t1  = add_mod(rx1_1_reg, rm0_1);
    assign a_u1  = add_mod(rx_1_reg, rm1_1);
    assign a_v1  = add_mod(rx1_1_reg, rm1_1);
    assign cbx1  = t2x_1_reg * fx_1_reg;
    assign cby1  = t2y_1_reg * fy_1_reg;
    assign wr1   = b1_reg.valid && !b1_reg.eval &&
                   (32'(b1_reg.widx) < 32'(PERM_SIZE));

    fgn_perm_ram #(.DEPTH(PERM_SIZE)) u_low_ram (
        .clk     (clk),
        .we      (wr1),
        .waddr   (PIDX_W'(b1_reg.widx)),
        .wdata   (b1_reg.wval),
        .raddr_a (a_s1),
        .raddr_b (a_t1),
        .rdata_a (g_s2),
        .rdata_b (g_t2)
    );

    fgn_perm_ram #(.DEPTH(PERM_SIZE)) u_high_ram (
        .clk     (clk),
        .we      (wr1),
        .waddr   (PIDX_W'(b1_reg.widx)),
        .wdata   (b1_reg.wval),
        .raddr_a (a_u1),
        .raddr_b (a_v1),
        .rdata_a (g_u2),
        .rdata_b (g_v2)
    );

    logic [FW-1:0] fx_2_reg, fy_2_reg, t2x_2_reg, t2y_2_reg, t3x_2_reg, t3y_2_reg;

    always_ff @(posedge clk)
    begin
        fx_2_reg  <= fx_1_reg;
        fy_2_reg  <= fy_1_reg;
        t2x_2_reg <= t2x_1_reg;
        t2y_2_reg <= t2y_1_reg;
        t3x_2_reg <= cbx1[2*FW-1:FW];
        t3y_2_reg <= cby1[2*FW-1:FW];
    end

    // ---------------- stage 2: dot products and s-curve
    logic signed [GC_W-1:0] dx0_2, dx1_2, dy0_2, dy1_2;
    logic [fgn_pkg::CURVE_W+1:0] c3x2, c3y2;

    assign dx0_2 = $signed(GC_W'(fx_2_reg));
    assign dy0_2 = $signed(GC_W'(fy_2_reg));
    assign dx1_2 = dx0_2 - fgn_pkg::GRAD_ONE;
    assign dy1_2 = dy0_2 - fgn_pkg::GRAD_ONE;
    assign c3x2  = (fgn_pkg::CURVE_W+2)'(t2x_2_reg) * 3'd3
                   - ((fgn_pkg::CURVE_W+2)'(t3x_2_reg) << 1);
    assign c3y2  = (fgn_pkg::CURVE_W+2)'(t2y_2_reg) * 3'd3
                   - ((fgn_pkg::CURVE_W+2)'(t3y_2_reg) << 1);

    logic signed [DOT_W-1:0] ds_3_reg, dt_3_reg, du_3_reg, dv_3_reg;
    logic [fgn_pkg::CURVE_W-1:0] cx_3_reg, cy_3_reg;

    always_ff @(posedge clk)
    begin
        ds_3_reg <= corner_dot(g_s2[2:0], dx0_2, dy0_2);
        dt_3_reg <= corner_dot(g_t2[2:0], dx1_2, dy0_2);
        du_3_reg <= corner_dot(g_u2[2:0], dx0_2, dy1_2);
        dv_3_reg <= corner_dot(g_v2[2:0], dx1_2, dy1_2);
        cx_3_reg <= c3x2[fgn_pkg::CURVE_W-1:0];
        cy_3_reg <= c3y2[fgn_pkg::CURVE_W-1:0];
    end

    // ---------------- stage 3: cosine weight table
    logic [4:0] lox3, hix3, loy3, hiy3;
    logic [fgn_pkg::WT_W-1:0] dfx3, dfy3;
    logic [fgn_pkg::COS_PR_W-1:0] cpx3, cpy3;

    assign lox3 = {1'b0, cx_3_reg[15:12]};
    assign loy3 = {1'b0, cy_3_reg[15:12]};
    assign hix3 = lox3 + 5'd1;
    assign hiy3 = loy3 + 5'd1;
    assign dfx3 = fgn_pkg::COS_WEIGHT[hix3] - fgn_pkg::COS_WEIGHT[lox3];
    assign dfy3 = fgn_pkg::COS_WEIGHT[hiy3] - fgn_pkg::COS_WEIGHT[loy3];
    assign cpx3 = dfx3 * cx_3_reg[fgn_pkg::COS_FR_W-1:0];
    assign cpy3 = dfy3 * cy_3_reg[fgn_pkg::COS_FR_W-1:0];

    logic signed [DOT_W-1:0] ds_4_reg, dt_4_reg, du_4_reg, dv_4_reg;
    logic [fgn_pkg::CURVE_W-1:0] cx_4_reg, cy_4_reg;
    logic [fgn_pkg::WT_W-1:0] cbx_4_reg, cby_4_reg;
    logic [fgn_pkg::COS_PR_W-1:0] cpx_4_reg, cpy_4_reg;

    // A curve value of one or more saturates the cosine weight at one.
    always_ff @(posedge clk)
    begin
        ds_4_reg  <= ds_3_reg;
        dt_4_reg  <= dt_3_reg;
        du_4_reg  <= du_3_reg;
        dv_4_reg  <= dv_3_reg;
        cx_4_reg  <= cx_3_reg;
        cy_4_reg  <= cy_3_reg;
        cbx_4_reg <= cx_3_reg[16] ? fgn_pkg::COS_WEIGHT[16] : fgn_pkg::COS_WEIGHT[lox3];
        cby_4_reg <= cy_3_reg[16] ? fgn_pkg::COS_WEIGHT[16] : fgn_pkg::COS_WEIGHT[loy3];
        cpx_4_reg <= cx_3_reg[16] ? '0 : cpx3;
        cpy_4_reg <= cy_3_reg[16] ? '0 : cpy3;
    end

    // ---------------- stage 4: horizontal blend products
    logic [fgn_pkg::WT_W-1:0] wx4, wy4;
    logic signed [DOT_W:0]    dts4, dvu4;
    logic signed [2*BL_W-1:0] p0_4, p1_4;

    assign wx4  = cfg.interp_mode
                  ? cbx_4_reg + fgn_pkg::WT_W'(cpx_4_reg >> fgn_pkg::COS_FR_W)
                  : cx_4_reg;
    assign wy4  = cfg.interp_mode
                  ? cby_4_reg + fgn_pkg::WT_W'(cpy_4_reg >> fgn_pkg::COS_FR_W)
                  : cy_4_reg;
    assign dts4 = (DOT_W+1)'(dt_4_reg) - (DOT_W+1)'(ds_4_reg);
    assign dvu4 = (DOT_W+1)'(dv_4_reg) - (DOT_W+1)'(du_4_reg);
    assign p0_4 = dts4 * $signed({1'b0, wx4});
    assign p1_4 = dvu4 * $signed({1'b0, wx4});

    logic signed [DOT_W-1:0]  ds_5_reg, du_5_reg;
    logic signed [2*BL_W-1:0] p0_5_reg, p1_5_reg;
    logic [fgn_pkg::WT_W-1:0] wy_5_reg, wy_6_reg;

    always_ff @(posedge clk)
    begin
        ds_5_reg <= ds_4_reg;
        du_5_reg <= du_4_reg;
        p0_5_reg <= p0_4;
        p1_5_reg <= p1_4;
        wy_5_reg <= wy4;
        wy_6_reg <= wy_5_reg;
    end

    // ---------------- stages 5 to 7: vertical blend
    logic signed [BL_W-1:0] b0_6_reg, b1_6_reg, b0_7_reg, n_8_reg;
    logic signed [BL_W:0]   d6;
    logic signed [2*BL_W-1:0] p2_6, p2_7_reg;

    assign d6   = (BL_W+1)'(b1_6_reg) - (BL_W+1)'(b0_6_reg);
    assign p2_6 = d6 * $signed({1'b0, wy_6_reg});

    always_ff @(posedge clk)
    begin
        b0_6_reg <= BL_W'(ds_5_reg) + BL_W'(p0_5_reg >>> FW);
        b1_6_reg <= BL_W'(du_5_reg) + BL_W'(p1_5_reg >>> FW);
        b0_7_reg <= b0_6_reg;
        p2_7_reg <= p2_6;
        n_8_reg  <= b0_7_reg + BL_W'(p2_7_reg >>> FW);
    end

    // ---------------- stages 8 and 9: amplitude and accumulation
    logic signed [2*BL_W-1:0] np8;
    logic [fgn_pkg::AMP_W+fgn_pkg::PERS_W-1:0] ap8;
    logic signed [2*BL_W-1:0] np_9_reg;
    logic signed [fgn_pkg::ACC_W-1:0] contrib9;
    logic active;

    assign np8    = n_8_reg * $signed({1'b0, b8_reg.amp});
    assign ap8    = b8_reg.amp * cfg.persistence;
    assign active = (32'(cfg.octave_count) > 32'(OCTAVE));

    always_ff @(posedge clk)
    begin
        np_9_reg <= np8;
    end

    assign contrib9 = active ? fgn_pkg::ACC_W'(np_9_reg >>> FW) : '0;

    always_comb
    begin
        b9_next      = b8_reg;
        b9_next.amp  = ap8[fgn_pkg::AMP_W+FW-1:FW];
        b10_next     = b9_reg;
        b10_next.acc = b9_reg.acc + contrib9;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_reg  <= '0;
            b2_reg  <= '0;
            b3_reg  <= '0;
            b4_reg  <= '0;
            b5_reg  <= '0;
            b6_reg  <= '0;
            b7_reg  <= '0;
            b8_reg  <= '0;
            b9_reg  <= '0;
            b10_reg <= '0;
        end
        else
        begin
            b1_reg  <= beat_in;
            b2_reg  <= b1_reg;
            b3_reg  <= b2_reg;
            b4_reg  <= b3_reg;
            b5_reg  <= b4_reg;
            b6_reg  <= b5_reg;
            b7_reg  <= b6_reg;
            b8_reg  <= b7_reg;
            b9_reg  <= b9_next;
            b10_reg <= b10_next;
        end
    end

    assign beat_out  = b10_reg;
    assign res_x_out = nrx_reg[9];
    assign res_y_out = nry_reg[9];

endmodule

>>> rtl/fractal_gradient_noise_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractal_gradient_noise_2d
// Fractal 2D gradient noise: a front end and a chain of octave cells.
// ----------------------------------------------------------------------------
// Throughput: one beat (sample or table write) accepted every cycle; busy is
// always low. A sample's result passes through three front stages, ten per
// octave cell and one output register before noise_valid rises.
// The result strobe cannot be stalled. Reset clears the pipeline valid bits
// and loads the register defaults; the table copies are not cleared.
module fractal_gradient_noise_2d #(
    parameter int PERM_SIZE   = fgn_pkg::PERM_SIZE_DEF,
    parameter int MAX_OCTAVES = fgn_pkg::MAX_OCTAVES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                op,
    input  logic [fgn_pkg::COORD_W-1:0]         coord_x,
    input  logic [fgn_pkg::COORD_W-1:0]         coord_y,
    input  logic [fgn_pkg::PERM_W-1:0]          perm_index,
    input  logic [fgn_pkg::PERM_W-1:0]          perm_value,
    input  logic                                cfg_we,
    input  logic [fgn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fgn_pkg::FREQ_W-1:0]          cfg_wdata,
    output logic                                noise_valid,
    output logic signed [fgn_pkg::OUT_W-1:0]    noise_value
);

    localparam int PIDX_W     = $clog2(PERM_SIZE);
    localparam int RESULT_LAG = fgn_pkg::FRONT_STAGES
                                + fgn_pkg::CELL_STAGES * MAX_OCTAVES + 1;

    fgn_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.octave_count   <= fgn_pkg::OCT_W'(8);
            cfg_reg.persistence    <= fgn_pkg::PERS_W'(42598);
            cfg_reg.interp_mode    <= 1'b0;
            cfg_reg.base_frequency <= fgn_pkg::FREQ_W'(65536);
        end
        else if (cfg_we)
        begin
            unique case (fgn_pkg::cfg_reg_t'(cfg_index))
                fgn_pkg::REG_OCTAVES: cfg_reg.octave_count   <= cfg_wdata[fgn_pkg::OCT_W-1:0];
                fgn_pkg::REG_PERSIST: cfg_reg.persistence    <= cfg_wdata[fgn_pkg::PERS_W-1:0];
                fgn_pkg::REG_INTERP:  cfg_reg.interp_mode    <= cfg_wdata[0];
                fgn_pkg::REG_FREQ:    cfg_reg.base_frequency <= cfg_wdata;
            endcase
        end
    end

    assign busy = 1'b0;

    fgn_pkg::beat_t    chain_beat [MAX_OCTAVES+1];
    logic [PIDX_W-1:0] chain_rx   [MAX_OCTAVES+1];
    logic [PIDX_W-1:0] chain_ry   [MAX_OCTAVES+1];

    fgn_front #(.PERM_SIZE(PERM_SIZE)) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (start && !busy),
        .op             (op),
        .coord_x        (coord_x),
        .coord_y        (coord_y),
        .perm_index     (perm_index),
        .perm_value     (perm_value),
        .base_frequency (cfg_reg.base_frequency),
        .beat_out       (chain_beat[0]),
        .res_x          (chain_rx[0]),
        .res_y          (chain_ry[0])
    );

    for (genvar k = 0; k < MAX_OCTAVES; k++)
    begin : g_octave
        fgn_cell #(.PERM_SIZE(PERM_SIZE), .OCTAVE(k)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cfg       (cfg_reg),
            .beat_in   (chain_beat[k]),
            .res_x_in  (chain_rx[k]),
            .res_y_in  (chain_ry[k]),
            .beat_out  (chain_beat[k+1]),
            .res_x_out (chain_rx[k+1]),
            .res_y_out (chain_ry[k+1])
        );
    end

    fgn_pkg::beat_t last_beat;
    logic noise_valid_reg, noise_valid_next;
    logic signed [fgn_pkg::OUT_W-1:0] noise_value_reg, noise_value_next;

    assign last_beat        = chain_beat[MAX_OCTAVES];
    assign noise_valid_next = last_beat.valid && last_beat.eval;

    // The sum is scaled by eight into Q4.19, saturating at the 24-bit range.
    always_comb
    begin
        priority if (last_beat.acc > fgn_pkg::ACC_HI)
        begin
            noise_value_next = fgn_pkg::OUT_MAX;
        end
        else if (last_beat.acc < fgn_pkg::ACC_LO)
        begin
            noise_value_next = fgn_pkg::OUT_MIN;
        end
        else
        begin
            noise_value_next = {last_beat.acc[fgn_pkg::OUT_W-4:0], 3'b000};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_valid_reg <= 1'b0;
        end
        else
        begin
            noise_valid_reg <= noise_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        noise_value_reg <= noise_value_next;
    end

    assign noise_valid = noise_valid_reg;
    assign noise_value = noise_value_reg;

    // A result beat always traces back to a sample accepted a fixed time ago.
    a_result_from_sample: assert property (
        @(posedge clk) disable iff (!rst_n)
        noise_valid |-> $past(start && op, RESULT_LAG)
    ) else $error("result without a matching sample");

    // A table write never produces a result.
    a_write_silent: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !op) |-> ##RESULT_LAG !noise_valid
    ) else $error("table write produced a result");

    // The last cell's residues feed no further octave but must stay in table range.
    a_residue_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        chain_beat[MAX_OCTAVES].valid |->
            (32'(chain_rx[MAX_OCTAVES]) < 32'(PERM_SIZE)) &&
            (32'(chain_ry[MAX_OCTAVES]) < 32'(PERM_SIZE))
    ) else $error("cell residue out of table range");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractal gradient noise testbench
// Loads the permutation table, then runs phases of directed and random noise
// samples and table writes under several register settings. Each result is
// checked against a fixed-point noise predictor kept inside this bench.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DRAIN_CYCLES = 100;
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    typedef struct {
        logic        op;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  idx;
        logic [7:0]  val;
    } sample_t;

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    logic                               op;
    logic [fgn_pkg::COORD_W-1:0]        coord_x;
    logic [fgn_pkg::COORD_W-1:0]        coord_y;
    logic [fgn_pkg::PERM_W-1:0]         perm_index;
    logic [fgn_pkg::PERM_W-1:0]         perm_value;
    logic                               cfg_we;
    logic [fgn_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [fgn_pkg::FREQ_W-1:0]         cfg_wdata;
    logic                               noise_valid;
    logic signed [fgn_pkg::OUT_W-1:0]   noise_value;

    sample_t                            pending[$];
    logic signed [fgn_pkg::OUT_W-1:0]   expected_noise[$];
    logic [7:0]                         perm_copy[256];
    logic [3:0]                         oct_reg;
    logic [15:0]                        pers_reg;
    logic                               interp_reg;
    logic [23:0]                        freq_reg;
    int                                 errors;
    int                                 evals_checked;
    int                                 writes_taken;
    int                                 burst_left;
    int                                 gap_left;
    bit                                 beat_taken;

    fractal_gradient_noise_2d u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .coord_x(coord_x), .coord_y(coord_y), .perm_index(perm_index),
        .perm_value(perm_value), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .noise_valid(noise_valid), .noise_value(noise_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("fractal_gradient_noise_2d verification failed");
        $finish;
    end

    function automatic longint grad_comp(input logic [2:0] g, input bit y_axis);
        longint gx[8] = '{65536, 46341, 0, -46341, -65536, -46341, 0, 46341};
        longint gy[8] = '{0, 46341, 65536, 46341, 0, -46341, -65536, -46341};
        return y_axis ? gy[g] : gx[g];
    endfunction

    function automatic longint cell_dot(input longint ci, input longint cj,
                                        input longint dx, input longint dy);
        logic [7:0] row;
        logic [7:0] h;
        row = perm_copy[cj % 256];
        h = perm_copy[((ci % 256) + longint'(row)) % 256];
        return (grad_comp(h[2:0], 0) * dx + grad_comp(h[2:0], 1) * dy) >>> 16;
    endfunction

    function automatic longint fade(input longint t);
        longint t2;
        longint t3;
        t2 = (t * t) >> 16;
        t3 = (t2 * t) >> 16;
        return (3 * t2 - 2 * t3) & 64'hFFFF_FFFF;
    endfunction

    function automatic longint cos_weight_of(input longint c);
        longint i;
        longint fr;
        longint lo;
        longint hi;
        i = c >> 12;
        fr = c & 64'hFFF;
        if (i >= 16)
            return longint'(fgn_pkg::COS_WEIGHT[16]);
        lo = longint'(fgn_pkg::COS_WEIGHT[i]);
        hi = longint'(fgn_pkg::COS_WEIGHT[i+1]);
        return lo + (((hi - lo) * fr) >> 12);
    endfunction

    function automatic longint mix(input longint a, input longint b, input longint w);
        return a + (((b - a) * w) >>> 16);
    endfunction

    function automatic longint octave_value(input longint x, input longint y, input int k);
        longint sx, sy, xi, yi, fx, fy, s, t, u, v, cx, cy;
        sx = (x * longint'(freq_reg)) << k;
        sy = (y * longint'(freq_reg)) << k;
        xi = sx >> 24;
        yi = sy >> 24;
        fx = (sx >> 8) & 64'hFFFF;
        fy = (sy >> 8) & 64'hFFFF;
        s = cell_dot(xi, yi, fx, fy);
        t = cell_dot(xi + 1, yi, fx - 65536, fy);
        u = cell_dot(xi, yi + 1, fx, fy - 65536);
        v = cell_dot(xi + 1, yi + 1, fx - 65536, fy - 65536);
        cx = fade(fx);
        cy = fade(fy);
        if (interp_reg)
        begin
            cx = cos_weight_of(cx);
            cy = cos_weight_of(cy);
        end
        return mix(mix(s, t, cx), mix(u, v, cx), cy);
    endfunction

    function automatic logic signed [fgn_pkg::OUT_W-1:0] fractal_noise(
        input logic [15:0] x,
        input logic [15:0] y
    );
        longint total;
        longint amp;
        int n;
        total = 0;
        amp = 65536;
        n = (oct_reg > 4'd8) ? 8 : int'(oct_reg);
        for (int k = 0; k < n; k++)
        begin
            total += (octave_value(longint'(x), longint'(y), k) * amp) >>> 16;
            amp = (amp * longint'(pers_reg)) >> 16;
        end
        total *= 8;
        if (total > 8388607)
            total = 8388607;
        if (total < -8388608)
            total = -8388608;
        return total[fgn_pkg::OUT_W-1:0];
    endfunction

    // Driver: bursts of beats separated by random gaps.
    always @(negedge clk)
    begin
        if (rst_n && (!start || beat_taken))
        begin
            if (gap_left > 0 || pending.size() == 0)
            begin
                start <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
            else
            begin
                sample_t s;
                s = pending.pop_front();
                start <= 1'b1;
                op <= s.op;
                coord_x <= s.x;
                coord_y <= s.y;
                perm_index <= s.idx;
                perm_value <= s.val;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = int'($urandom_range(1, 24));
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 7));
                end
            end
        end
    end

    // Monitor: tracks accepted beats and register writes, checks results.
    always @(posedge clk)
    begin
        beat_taken = 1'b0;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (fgn_pkg::cfg_reg_t'(cfg_index))
                    fgn_pkg::REG_OCTAVES: oct_reg = cfg_wdata[3:0];
                    fgn_pkg::REG_PERSIST: pers_reg = cfg_wdata[15:0];
                    fgn_pkg::REG_INTERP:  interp_reg = cfg_wdata[0];
                    fgn_pkg::REG_FREQ:    freq_reg = cfg_wdata;
                endcase
            end
            if (noise_valid)
            begin
                if (expected_noise.size() == 0)
                begin
                    $error("noise_value: unexpected result %0d", noise_value);
                    errors++;
                end
                else
                begin
                    logic signed [fgn_pkg::OUT_W-1:0] want;
                    want = expected_noise.pop_front();
                    evals_checked++;
                    if (noise_value !== want)
                    begin
                        $error("noise_value: expected %0d, got %0d", want, noise_value);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                beat_taken = 1'b1;
                if (op == OP_EVAL)
                    expected_noise.insert(expected_noise.size(),
                                          fractal_noise(coord_x, coord_y));
                else
                begin
                    perm_copy[perm_index] = perm_value;
                    writes_taken++;
                end
            end
        end
    end

    task automatic write_reg(input fgn_pkg::cfg_reg_t r, input logic [23:0] d);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= r;
        cfg_wdata <= d;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_eval(input logic [15:0] x, input logic [15:0] y);
        sample_t s;
        s.op = OP_EVAL;
        s.x = x;
        s.y = y;
        s.idx = 8'($urandom);
        s.val = 8'($urandom);
        pending.insert(pending.size(), s);
    endtask

    task automatic add_write(input logic [7:0] i, input logic [7:0] v);
        sample_t s;
        s.op = OP_WRITE;
        s.x = 16'($urandom);
        s.y = 16'($urandom);
        s.idx = i;
        s.val = v;
        pending.insert(pending.size(), s);
    endtask

    task automatic drain();
        while (pending.size() != 0 || start || expected_noise.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(input int count);
        logic [15:0] x, y;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                add_write(8'($urandom), 8'($urandom));
            else
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        x = 16'($urandom_range(0, 63));
                        y = 16'($urandom_range(0, 63));
                    end
                    1:
                    begin
                        x = 16'hFFFF - 16'($urandom_range(0, 15));
                        y = 16'($urandom);
                    end
                    default:
                    begin
                        x = 16'($urandom);
                        y = 16'($urandom);
                    end
                endcase
                add_eval(x, y);
            end
        end
        drain();
    endtask

    initial
    begin
        logic [7:0] shuffle[256];
        logic [7:0] tmp;
        int j;
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_WRITE;
        coord_x = '0;
        coord_y = '0;
        perm_index = '0;
        perm_value = '0;
        cfg_we = 1'b0;
        cfg_index = fgn_pkg::REG_OCTAVES;
        cfg_wdata = '0;
        oct_reg = 4'd8;
        pers_reg = 16'd42598;
        interp_reg = 1'b0;
        freq_reg = 24'd65536;
        errors = 0;
        evals_checked = 0;
        writes_taken = 0;
        burst_left = 8;
        gap_left = 0;
        beat_taken = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Every table entry is loaded before the first sample reads it.
        for (int i = 0; i < 256; i++)
            shuffle[i] = 8'(i);
        for (int i = 255; i > 0; i--)
        begin
            j = int'($urandom_range(0, i));
            tmp = shuffle[i];
            shuffle[i] = shuffle[j];
            shuffle[j] = tmp;
        end
        for (int i = 0; i < 256; i++)
            add_write(8'(i), shuffle[i]);
        drain();

        // Directed corners under the reset settings.
        add_eval(16'd0, 16'd0);
        add_eval(16'hFFFF, 16'hFFFF);
        add_eval(16'd0, 16'hFFFF);
        add_eval(16'hFFFF, 16'd0);
        add_eval(16'd1, 16'd1);
        add_eval(16'h8000, 16'h7FFF);
        add_write(8'd255, 8'd255);
        add_write(8'd0, 8'd0);
        add_eval(16'd255, 16'd255);
        add_eval(16'd256, 16'd0);
        random_phase(50);

        write_reg(fgn_pkg::REG_OCTAVES, 24'd1);
        write_reg(fgn_pkg::REG_PERSIST, 24'd0);
        write_reg(fgn_pkg::REG_INTERP, 24'd1);
        write_reg(fgn_pkg::REG_FREQ, 24'hFFFFFF);
        random_phase(60);

        // Zero octaves gives zero noise.
        write_reg(fgn_pkg::REG_OCTAVES, 24'd0);
        write_reg(fgn_pkg::REG_PERSIST, 24'd65535);
        write_reg(fgn_pkg::REG_INTERP, 24'd0);
        write_reg(fgn_pkg::REG_FREQ, 24'd1);
        random_phase(30);

        // An octave count above the maximum sums the maximum.
        write_reg(fgn_pkg::REG_OCTAVES, 24'd15);
        write_reg(fgn_pkg::REG_INTERP, 24'd1);
        write_reg(fgn_pkg::REG_FREQ, 24'd4096);
        random_phase(60);

        // Zero frequency puts every sample on the cell origin.
        write_reg(fgn_pkg::REG_OCTAVES, 24'd8);
        write_reg(fgn_pkg::REG_PERSIST, 24'd32768);
        write_reg(fgn_pkg::REG_FREQ, 24'd0);
        random_phase(30);

        write_reg(fgn_pkg::REG_OCTAVES, 24'd4);
        write_reg(fgn_pkg::REG_PERSIST, 24'd65535);
        write_reg(fgn_pkg::REG_INTERP, 24'd0);
        write_reg(fgn_pkg::REG_FREQ, 24'h100000);
        random_phase(60);

        for (int p = 0; p < 3; p++)
        begin
            write_reg(fgn_pkg::REG_OCTAVES, 24'($urandom_range(1, 8)));
            write_reg(fgn_pkg::REG_PERSIST, 24'($urandom_range(0, 65535)));
            write_reg(fgn_pkg::REG_INTERP, 24'($urandom_range(0, 1)));
            write_reg(fgn_pkg::REG_FREQ, 24'($urandom_range(1, 24'hFFFFFF)));
            random_phase(50);
        end

        $display("Checked %0d noise samples and %0d table writes over nine register settings.",
                 evals_checked, writes_taken);
        if (errors == 0)
            $display("fractal_gradient_noise_2d verification clean");
        else
            $display("fractal_gradient_noise_2d verification failed");
        $finish;
    end
endmodule

>>> filelist.f
rtl/fgn_pkg.sv
rtl/fgn_perm_ram.sv
rtl/fgn_front.sv
rtl/fgn_cell.sv
rtl/fractal_gradient_noise_2d.sv
tb/testbench.sv
